FILE: src/ple_pkg.sv
// shared types, constants and word conversions for the positional list engine
// used by ple_ctrl, ple_dp and positional_list_engine; no dependencies
package ple_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;

  localparam int POS_W = 7;
  localparam int LEN_W = 7;
  localparam int VAL_W = 32;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PUT,
    ST_READ_WAIT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_shift;
    logic rd_pos;
    logic wr_shift;
    logic wr_value;
    logic cnt_inc;
    logic cnt_dec;
    logic cnt_clr;
    logic finish;
    logic fin_ok;
    logic fin_read;
  } ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic pos_ok;
    logic shift_more;
    logic shift_more_next;
  } stat_t;

  function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [VAL_W-1:0] v);
    logic signed [63:0] ext;
    ext = 64'(v);
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VAL_W-1:0] from_word(input logic signed [DATA_WIDTH-1:0] w);
    logic signed [63:0] ext;
    ext = 64'(w);
    return ext[VAL_W-1:0];
  endfunction

endpackage

FILE: src/positional_list_engine.sv
// Ordered list of up to 64 signed words with insert, remove, read and clear at a
// position. A request is taken when start is high and busy is low; its result shows
// on ok, read_value and length when done is high for exactly one cycle, stays there
// until the next result, and cannot be held off. Entries sit in a single-port-write,
// registered-read memory, so each entry moved takes a read state and a write state.
// done is high in the first cycle that busy is low, so the next request may be taken
// while the result is shown.
// top level of the positional list engine; instantiates ple_ctrl and ple_dp
// depends on ple_pkg
module positional_list_engine (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        cmd,
  input  logic [ple_pkg::POS_W-1:0]         position,
  input  logic signed [ple_pkg::VAL_W-1:0]  value,
  output logic                              done,
  output logic                              ok,
  output logic signed [ple_pkg::VAL_W-1:0]  read_value,
  output logic [ple_pkg::LEN_W-1:0]         length
);

  ple_pkg::ctl_t  ctl;
  ple_pkg::stat_t stat;

  ple_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .ctl   (ctl)
  );

  ple_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmd        (cmd),
    .position   (position),
    .value      (value),
    .stat       (stat),
    .done       (done),
    .ok         (ok),
    .read_value (read_value),
    .length     (length)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("request taken but engine not busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (read_value == '0))
    else $error("failed request returned a nonzero value");

  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    done |-> (ple_pkg::CMP_W'(length) <= ple_pkg::CMP_W'(ple_pkg::CAPACITY)))
    else $error("length above capacity");

endmodule

FILE: src/ple_ctrl.sv
// sequencer for the positional list engine: accepts a request and steps
// the datapath through checks, element moves and the result; uses ple_pkg
module ple_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ple_pkg::stat_t   stat,
  output logic             busy,
  output ple_pkg::ctl_t    ctl
);

  ple_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ple_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != ple_pkg::ST_IDLE);
    unique case (state)
      ple_pkg::ST_IDLE: begin
        if (start) begin
          ctl.load   = 1'b1;
          state_next = ple_pkg::ST_CHECK;
        end
      end
      ple_pkg::ST_CHECK: begin
        unique case (stat.cmd)
          ple_pkg::CMD_INSERT: begin
            if (!stat.pos_ok) begin
              ctl.finish = 1'b1;
              state_next = ple_pkg::ST_IDLE;
            end else if (stat.shift_more) begin
              state_next = ple_pkg::ST_SHIFT_RD;
            end else begin
              state_next = ple_pkg::ST_PUT;
            end
          end
          ple_pkg::CMD_REMOVE: begin
            if (!stat.pos_ok) begin
              ctl.finish = 1'b1;
              state_next = ple_pkg::ST_IDLE;
            end else if (stat.shift_more) begin
              state_next = ple_pkg::ST_SHIFT_RD;
            end else begin
              ctl.cnt_dec = 1'b1;
              ctl.finish  = 1'b1;
              ctl.fin_ok  = 1'b1;
              state_next  = ple_pkg::ST_IDLE;
            end
          end
          ple_pkg::CMD_READ: begin
            if (!stat.pos_ok) begin
              ctl.finish = 1'b1;
              state_next = ple_pkg::ST_IDLE;
            end else begin
              ctl.rd_pos = 1'b1;
              state_next = ple_pkg::ST_READ_WAIT;
            end
          end
          ple_pkg::CMD_CLEAR: begin
            ctl.cnt_clr = 1'b1;
            ctl.finish  = 1'b1;
            ctl.fin_ok  = 1'b1;
            state_next  = ple_pkg::ST_IDLE;
          end
          default: begin
            state_next = ple_pkg::ST_IDLE;
          end
        endcase
      end
      ple_pkg::ST_SHIFT_RD: begin
        ctl.rd_shift = 1'b1;
        state_next   = ple_pkg::ST_SHIFT_WR;
      end
      ple_pkg::ST_SHIFT_WR: begin
        ctl.wr_shift = 1'b1;
        if (stat.shift_more_next) begin
          state_next = ple_pkg::ST_SHIFT_RD;
        end else if (stat.cmd == ple_pkg::CMD_INSERT) begin
          state_next = ple_pkg::ST_PUT;
        end else begin
          ctl.cnt_dec = 1'b1;
          ctl.finish  = 1'b1;
          ctl.fin_ok  = 1'b1;
          state_next  = ple_pkg::ST_IDLE;
        end
      end
      ple_pkg::ST_PUT: begin
        ctl.wr_value = 1'b1;
        ctl.cnt_inc  = 1'b1;
        ctl.finish   = 1'b1;
        ctl.fin_ok   = 1'b1;
        state_next   = ple_pkg::ST_IDLE;
      end
      ple_pkg::ST_READ_WAIT: begin
        ctl.finish   = 1'b1;
        ctl.fin_ok   = 1'b1;
        ctl.fin_read = 1'b1;
        state_next   = ple_pkg::ST_IDLE;
      end
      default: begin
        state_next = ple_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/ple_dp.sv
// datapath of the positional list engine: entry memory, count, move cursor,
// request and result registers; uses ple_pkg
module ple_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  ple_pkg::ctl_t                     ctl,
  input  logic [1:0]                        cmd,
  input  logic [ple_pkg::POS_W-1:0]         position,
  input  logic signed [ple_pkg::VAL_W-1:0]  value,
  output ple_pkg::stat_t                    stat,
  output logic                              done,
  output logic                              ok,
  output logic signed [ple_pkg::VAL_W-1:0]  read_value,
  output logic [ple_pkg::LEN_W-1:0]         length
);

  logic [ple_pkg::DATA_WIDTH-1:0] mem [ple_pkg::CAPACITY];

  ple_pkg::cmd_t                  req_cmd;
  logic [ple_pkg::CMP_W-1:0]      req_pos;
  logic [ple_pkg::DATA_WIDTH-1:0] req_word;
  logic [ple_pkg::CNT_W-1:0]      count, count_next;
  logic [ple_pkg::CNT_W-1:0]      idx;
  logic [ple_pkg::DATA_WIDTH-1:0] rd_data;

  logic [ple_pkg::CMP_W:0]        pos_w, cnt_w, idx_w;
  logic [ple_pkg::CNT_W-1:0]      idx_dn, idx_up;
  logic                           is_insert;
  logic                           rd_en, wr_en;
  logic [ple_pkg::IDX_W-1:0]      rd_addr, wr_addr;
  logic [ple_pkg::DATA_WIDTH-1:0] wr_data;

  assign pos_w     = (ple_pkg::CMP_W + 1)'(req_pos);
  assign cnt_w     = (ple_pkg::CMP_W + 1)'(count);
  assign idx_w     = (ple_pkg::CMP_W + 1)'(idx);
  assign idx_dn    = idx - 1'b1;
  assign idx_up    = idx + 1'b1;
  assign is_insert = (req_cmd == ple_pkg::CMD_INSERT);

  // status toward the sequencer
  always_comb begin
    stat.cmd = req_cmd;
    if (is_insert) begin
      stat.pos_ok = (pos_w <= cnt_w) &&
                    (cnt_w < (ple_pkg::CMP_W + 1)'(ple_pkg::CAPACITY));
      stat.shift_more      = (idx_w > pos_w);
      stat.shift_more_next = ((idx_w - 1'b1) > pos_w);
    end else begin
      stat.pos_ok          = (pos_w < cnt_w);
      stat.shift_more      = ((idx_w + 1'b1) < cnt_w);
      stat.shift_more_next = ((idx_w + 2'd2) < cnt_w);
    end
  end

  // memory port selection
  always_comb begin
    rd_en   = ctl.rd_shift | ctl.rd_pos;
    rd_addr = req_pos[ple_pkg::IDX_W-1:0];
    if (ctl.rd_shift) begin
      rd_addr = is_insert ? idx_dn[ple_pkg::IDX_W-1:0] : idx_up[ple_pkg::IDX_W-1:0];
    end
    wr_en   = ctl.wr_shift | ctl.wr_value;
    wr_addr = ctl.wr_shift ? idx[ple_pkg::IDX_W-1:0] : req_pos[ple_pkg::IDX_W-1:0];
    wr_data = ctl.wr_shift ? rd_data : req_word;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_comb begin
    count_next = count;
    if (ctl.cnt_clr) begin
      count_next = '0;
    end else if (ctl.cnt_inc) begin
      count_next = count + 1'b1;
    end else if (ctl.cnt_dec) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= ctl.finish;
    end
  end

  // request capture and move cursor
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      req_cmd  <= ple_pkg::cmd_t'(cmd);
      req_pos  <= ple_pkg::CMP_W'(position);
      req_word <= ple_pkg::to_word(value);
      if (ple_pkg::cmd_t'(cmd) == ple_pkg::CMD_INSERT) begin
        idx <= count;
      end else begin
        idx <= ple_pkg::CNT_W'(position);
      end
    end else if (ctl.wr_shift) begin
      idx <= is_insert ? idx_dn : idx_up;
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      ok         <= ctl.fin_ok;
      read_value <= ctl.fin_read ? ple_pkg::from_word(rd_data) : '0;
      length     <= ple_pkg::LEN_W'(count_next);
    end
  end

endmodule
